// ===== hdl/amos_pkg.sv =====
package amos_pkg;

	// Field and datapath widths.
	localparam int MIX_WIDTH     = 24;
	localparam int MAX_RING_LOG2 = 16;
	localparam int FRAC_W        = 16;
	localparam int ACC_W         = MIX_WIDTH + FRAC_W;
	localparam int DIFF_W        = ACC_W + 1;
	localparam int ALPHA_W       = 17;
	localparam int COEF_W        = ALPHA_W - 1;
	localparam int PROD_W        = DIFF_W + COEF_W + 1;
	localparam int VOL_W         = 9;
	localparam int FILT_W        = MIX_WIDTH + 1;
	localparam int SCALED_W      = FILT_W + VOL_W + 1;
	localparam int VOL_SHIFT     = 8;
	localparam int PTR_W         = MAX_RING_LOG2;
	localparam int LOG2_W        = 5;
	localparam int SAMPLE_W      = 16;
	localparam int SLOT_W        = 16;
	localparam int BYTE_W        = 8;
	localparam int IN_TDATA_W    = ((2 * MIX_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W   = ((SLOT_W + SAMPLE_W + 7) / 8) * 8;
	localparam int HALF_LSB      = 1 << (FRAC_W - 1);

	// Ring size limits and gain limits.
	localparam logic [LOG2_W-1:0] RING_LOG2_MIN = LOG2_W'(8);
	localparam logic [LOG2_W-1:0] RING_LOG2_MAX = LOG2_W'(MAX_RING_LOG2);
	localparam logic [VOL_W-1:0]  VOL_UNITY     = VOL_W'(256);
	localparam logic [BYTE_W-1:0] BYTE_OFFSET   = BYTE_W'(128);

	// Decoupling queue between front and back; depth is a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ALPHA_W;

	localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_EIGHT_BIT_MODE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE_LOG2 = CFG_IDX_W'(4);

	localparam logic [VOL_W-1:0]   RST_MASTER_VOLUME  = VOL_W'(179);
	localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA   = ALPHA_W'(65536);
	localparam logic               RST_EIGHT_BIT_MODE = 1'b0;
	localparam logic               RST_STEREO_MODE    = 1'b1;
	localparam logic [LOG2_W-1:0]  RST_RING_SIZE_LOG2 = LOG2_W'(14);

	// One accepted pair, classified by the front.
	typedef struct packed {
		logic signed [MIX_WIDTH-1:0] mix_left;
		logic signed [MIX_WIDTH-1:0] mix_right;
		logic                        end_of_block;
		logic                        emit_right;
	} item_t;

	// Configuration registers as seen by the back.
	typedef struct packed {
		logic [VOL_W-1:0]   master_volume;
		logic [ALPHA_W-1:0] filter_alpha;
		logic               eight_bit_mode;
		logic               stereo_mode;
		logic [LOG2_W-1:0]  ring_size_log2;
	} cfg_t;

	// Queue status between the modules.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== hdl/amos_queue.sv =====
module amos_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  amos_pkg::item_t   push_item,
	input  logic              pop,
	output amos_pkg::item_t   pop_item,
	output amos_pkg::q_status_t status
);

	amos_pkg::item_t mem_q [amos_pkg::QUEUE_DEPTH];
	logic [amos_pkg::QPTR_W-1:0] wr_q;
	logic [amos_pkg::QPTR_W-1:0] rd_q;
	logic [amos_pkg::QPTR_W:0]   count_q;

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_item     = mem_q[rd_q];
	assign status.full  = (count_q == (amos_pkg::QPTR_W + 1)'(amos_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

// ===== hdl/amos_front.sv =====
module amos_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [amos_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic                               s_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [amos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [amos_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  amos_pkg::q_status_t                q_status,
	output logic                               q_push,
	output amos_pkg::item_t                    q_item,
	output amos_pkg::cfg_t                     cfg
);

	amos_pkg::cfg_t cfg_q;

	// Register writes are taken in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_volume  <= amos_pkg::RST_MASTER_VOLUME;
			cfg_q.filter_alpha   <= amos_pkg::RST_FILTER_ALPHA;
			cfg_q.eight_bit_mode <= amos_pkg::RST_EIGHT_BIT_MODE;
			cfg_q.stereo_mode    <= amos_pkg::RST_STEREO_MODE;
			cfg_q.ring_size_log2 <= amos_pkg::RST_RING_SIZE_LOG2;
		end else if (cfg_valid) begin
			case (cfg_index)
				amos_pkg::REG_MASTER_VOLUME: begin
					cfg_q.master_volume <= cfg_data[amos_pkg::VOL_W-1:0];
				end
				amos_pkg::REG_FILTER_ALPHA: begin
					cfg_q.filter_alpha <= cfg_data[amos_pkg::ALPHA_W-1:0];
				end
				amos_pkg::REG_EIGHT_BIT_MODE: begin
					cfg_q.eight_bit_mode <= cfg_data[0];
				end
				amos_pkg::REG_STEREO_MODE: begin
					cfg_q.stereo_mode <= cfg_data[0];
				end
				amos_pkg::REG_RING_SIZE_LOG2: begin
					cfg_q.ring_size_log2 <= cfg_data[amos_pkg::LOG2_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

	// Accept a beat whenever the queue has room and tag it with its result count.
	assign s_axis_tready        = !q_status.full;
	assign q_push               = s_axis_tvalid && !q_status.full;
	assign q_item.mix_left      = s_axis_tdata[amos_pkg::MIX_WIDTH-1:0];
	assign q_item.mix_right     = s_axis_tdata[2*amos_pkg::MIX_WIDTH-1:amos_pkg::MIX_WIDTH];
	assign q_item.end_of_block  = s_axis_tlast;
	assign q_item.emit_right    = cfg_q.stereo_mode;

endmodule

// ===== hdl/amos_back.sv =====
module amos_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  amos_pkg::cfg_t                     cfg,
	input  amos_pkg::q_status_t                q_status,
	input  amos_pkg::item_t                    q_item,
	output logic                               q_pop,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [amos_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic                               m_axis_tlast,
	output logic                               m_axis_tuser
);

	localparam int V_W = amos_pkg::SCALED_W - amos_pkg::VOL_SHIFT;
	localparam logic signed [V_W-1:0] SAT_HI = V_W'(32'sd32767);
	localparam logic signed [V_W-1:0] SAT_LO = V_W'(-32'sd32768);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIFF  = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_ACC   = 7'b0001000,
		ST_ROUND = 7'b0010000,
		ST_VOL   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic   side_q;
	amos_pkg::item_t item_q;

	logic signed [amos_pkg::ACC_W-1:0]    acc_l_q;
	logic signed [amos_pkg::ACC_W-1:0]    acc_r_q;
	logic signed [amos_pkg::DIFF_W-1:0]   diff_q;
	logic signed [amos_pkg::PROD_W-1:0]   prod_q;
	logic signed [amos_pkg::FILT_W-1:0]   filt_q;
	logic signed [amos_pkg::SCALED_W-1:0] scaled_q;
	logic [amos_pkg::PTR_W-1:0]           ptr_q;

	logic                               out_valid_q;
	logic [amos_pkg::SLOT_W-1:0]        slot_q;
	logic [amos_pkg::SAMPLE_W-1:0]      sample_q;
	logic                               is_last_q;
	logic                               block_done_q;

	logic signed [amos_pkg::MIX_WIDTH-1:0] x_sel;
	logic signed [amos_pkg::ACC_W-1:0]     acc_sel;
	logic signed [amos_pkg::DIFF_W-1:0]    diff_next;
	logic signed [amos_pkg::PROD_W-1:0]    prod_next;
	logic signed [amos_pkg::PROD_W-1:0]    prod_rnd;
	logic signed [amos_pkg::ACC_W-1:0]     acc_next;
	logic signed [amos_pkg::ACC_W:0]       acc_rnd;
	logic [amos_pkg::VOL_W-1:0]            vol_eff;
	logic signed [V_W-1:0]                 v_shift;
	logic [amos_pkg::SAMPLE_W-1:0]         v_sat;
	logic [amos_pkg::SAMPLE_W-1:0]         sample_next;
	logic [amos_pkg::LOG2_W-1:0]           ring_log2;
	logic [amos_pkg::PTR_W:0]              mask_wide;
	logic [amos_pkg::PTR_W-1:0]            ring_mask;
	logic [amos_pkg::PTR_W-1:0]            slot_now;
	logic                                  emit;
	logic                                  last;
	logic                                  out_free;
	logic                                  load_out;

	// Operand selection for the side being worked on.
	assign x_sel   = side_q ? item_q.mix_right : item_q.mix_left;
	assign acc_sel = side_q ? acc_r_q : acc_l_q;

	// Filter arithmetic: difference, Q16 product, half-up rounded step.
	always_comb begin
		diff_next = {x_sel[amos_pkg::MIX_WIDTH-1], x_sel, {amos_pkg::FRAC_W{1'b0}}}
			- {acc_sel[amos_pkg::ACC_W-1], acc_sel};
		if (cfg.filter_alpha[amos_pkg::COEF_W]) begin
			// Alpha of one or above passes the difference through unscaled.
			prod_next = amos_pkg::PROD_W'(diff_q) <<< amos_pkg::FRAC_W;
		end else begin
			prod_next = diff_q * $signed({1'b0, cfg.filter_alpha[amos_pkg::COEF_W-1:0]});
		end
		prod_rnd = prod_q + amos_pkg::PROD_W'(amos_pkg::HALF_LSB);
		acc_next = acc_sel
			+ prod_rnd[amos_pkg::ACC_W+amos_pkg::FRAC_W-1:amos_pkg::FRAC_W];
		acc_rnd  = {acc_sel[amos_pkg::ACC_W-1], acc_sel}
			+ (amos_pkg::ACC_W + 1)'(amos_pkg::HALF_LSB);
	end

	// Gain limit, saturation and output format.
	always_comb begin
		vol_eff = (cfg.master_volume > amos_pkg::VOL_UNITY) ? amos_pkg::VOL_UNITY
			: cfg.master_volume;
		v_shift = scaled_q[amos_pkg::SCALED_W-1:amos_pkg::VOL_SHIFT];
		if (v_shift > SAT_HI) begin
			v_sat = SAT_HI[amos_pkg::SAMPLE_W-1:0];
		end else if (v_shift < SAT_LO) begin
			v_sat = SAT_LO[amos_pkg::SAMPLE_W-1:0];
		end else begin
			v_sat = v_shift[amos_pkg::SAMPLE_W-1:0];
		end
		if (cfg.eight_bit_mode) begin
			sample_next = {{(amos_pkg::SAMPLE_W - amos_pkg::BYTE_W){1'b0}},
				v_sat[amos_pkg::SAMPLE_W-1:amos_pkg::SAMPLE_W-amos_pkg::BYTE_W]
				^ amos_pkg::BYTE_OFFSET};
		end else begin
			sample_next = v_sat;
		end
	end

	// Ring mask from the clamped ring size.
	always_comb begin
		if (cfg.ring_size_log2 < amos_pkg::RING_LOG2_MIN) begin
			ring_log2 = amos_pkg::RING_LOG2_MIN;
		end else if (cfg.ring_size_log2 > amos_pkg::RING_LOG2_MAX) begin
			ring_log2 = amos_pkg::RING_LOG2_MAX;
		end else begin
			ring_log2 = cfg.ring_size_log2;
		end
		mask_wide = ({{amos_pkg::PTR_W{1'b0}}, 1'b1} << ring_log2)
			- {{amos_pkg::PTR_W{1'b0}}, 1'b1};
		ring_mask = mask_wide[amos_pkg::PTR_W-1:0];
		slot_now  = ptr_q & ring_mask;
	end

	// Emit control: left always goes out, right only in stereo.
	assign emit     = !side_q || item_q.emit_right;
	assign last     = side_q || !item_q.emit_right;
	assign out_free = !out_valid_q || m_axis_tready;
	assign load_out = (state_q == ST_EMIT) && emit && out_free;
	assign q_pop    = (state_q == ST_IDLE) && !q_status.empty;

	// Sequencer: one side at a time through the shared multiply path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q  <= 1'b0;
			acc_l_q <= '0;
			acc_r_q <= '0;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						side_q  <= 1'b0;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (side_q) begin
						acc_r_q <= acc_next;
					end else begin
						acc_l_q <= acc_next;
					end
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					state_q <= ST_VOL;
				end
				ST_VOL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!emit || out_free) begin
						if (emit) begin
							ptr_q <= (slot_now + 1'b1) & ring_mask;
						end
						if (side_q) begin
							state_q <= ST_IDLE;
						end else begin
							side_q  <= 1'b1;
							state_q <= ST_DIFF;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers between the sequencer steps.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= diff_next;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_next;
		end
		if (state_q == ST_ROUND) begin
			filt_q <= acc_rnd[amos_pkg::ACC_W:amos_pkg::FRAC_W];
		end
		if (state_q == ST_VOL) begin
			scaled_q <= filt_q * $signed({1'b0, vol_eff});
		end
		if (load_out) begin
			slot_q       <= amos_pkg::SLOT_W'(slot_now);
			sample_q     <= sample_next;
			is_last_q    <= last;
			block_done_q <= last && item_q.end_of_block;
		end
	end

	// Output register keeps a finished beat while the sequencer moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = amos_pkg::OUT_TDATA_W'({sample_q, slot_q});
	assign m_axis_tlast  = block_done_q;
	assign m_axis_tuser  = is_last_q;

endmodule

// ===== hdl/audio_mix_output_stage_core.sv =====
// Channel   Direction  Beat contents
// s_axis    in         one mixed stereo pair; tlast marks the end of a block
// m_axis    out        one ring slot and sample; tlast block done, tuser last of pair
// cfg       in         register index and write data, always ready
//
// In the back sequencer a pair is fetched from the queue, then each side runs in turn
// through the shared difference, multiply, accumulate, round, gain and output steps;
// both sides run even in mono.
// The front accepts pairs into a two-entry queue while the back is busy.
// A stalled output holds only the emit step; the filter state is already updated.
// Reset restores register defaults, clears both accumulators and the slot pointer.
module audio_mix_output_stage_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// mix_left [23:0], mix_right [47:24]
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [amos_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic                              s_axis_tlast,
	// slot_address [15:0], sample_value [31:16]
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [amos_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                              m_axis_tlast,
	// is_last [0]
	output logic                              m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [amos_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [amos_pkg::CFG_DATA_W-1:0]   cfg_data
);

	amos_pkg::q_status_t q_status;
	amos_pkg::item_t     push_item;
	amos_pkg::item_t     pop_item;
	amos_pkg::cfg_t      cfg;
	logic                push;
	logic                pop;

	// Front: beat intake, classification and registers.
	amos_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_status      (q_status),
		.q_push        (push),
		.q_item        (push_item),
		.cfg           (cfg)
	);

	// Short queue between front and back.
	amos_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	// Back: filter, gain, format and ring addressing.
	amos_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_status      (q_status),
		.q_item        (pop_item),
		.q_pop         (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== hdl/amos_checker.sv =====
module amos_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [amos_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                              m_axis_tlast,
	input logic                              m_axis_tuser,
	input logic                              cfg_valid,
	input logic                              cfg_ready
);

	// A stalled output beat holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	// Block done is only flagged on the final beat of a pair.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("block done on a beat that is not last of its pair");

	// Register writes never stall.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

	// No beat is offered while reset is held.
	assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind audio_mix_output_stage_core amos_checker u_amos_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);

// ===== tb/audio_mix_output_stage_core_tb.sv =====
`timescale 1ns / 1ps

module audio_mix_output_stage_core_tb;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 3;
	localparam int SETTLE_CYCLES  = 20;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES         = 9;
	localparam int PHASE_PAIRS    = 100;
	localparam int BURST_PAIRS    = 24;

	// Register indexes that decode to nothing.
	localparam logic [amos_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = amos_pkg::CFG_IDX_W'(5);
	localparam logic [amos_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = amos_pkg::CFG_IDX_W'(7);

	typedef struct packed {
		logic [amos_pkg::SLOT_W-1:0]   slot_address;
		logic [amos_pkg::SAMPLE_W-1:0] sample_value;
		logic                          is_last;
		logic                          block_done;
	} ring_write_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [amos_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;
	logic                                s_axis_tlast = 1'b0;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [amos_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
	logic                                m_axis_tlast;
	logic                                m_axis_tuser;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [amos_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [amos_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

	// Shadow copy of the registers and of the filter and ring state.
	logic [amos_pkg::VOL_W-1:0]          shadow_volume = amos_pkg::RST_MASTER_VOLUME;
	logic [amos_pkg::ALPHA_W-1:0]        shadow_alpha = amos_pkg::RST_FILTER_ALPHA;
	logic                                shadow_eight_bit = amos_pkg::RST_EIGHT_BIT_MODE;
	logic                                shadow_stereo = amos_pkg::RST_STEREO_MODE;
	logic [amos_pkg::LOG2_W-1:0]         shadow_ring_log2 = amos_pkg::RST_RING_SIZE_LOG2;
	longint                              lowpass_acc [2] = '{0, 0};
	logic [amos_pkg::SLOT_W-1:0]         next_slot = '0;

	ring_write_t              pending_writes [$];
	ring_write_t              oldest_write;
	int                       bad_beats = 0;
	int                       idle_cycles = 0;
	bit                       tx_gaps_on = 1'b1;
	bit                       rx_gaps_on = 1'b1;
	int                       hold_req = 0;
	int                       hold_ack = 0;
	int                       rx_stall = 0;

	audio_mix_output_stage_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sample values biased toward the extremes and toward zero.
	function automatic logic signed [amos_pkg::MIX_WIDTH-1:0] random_mix();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(amos_pkg::MIX_WIDTH - 1){1'b1}}};
			1: return {1'b1, {(amos_pkg::MIX_WIDTH - 1){1'b0}}};
			2: return amos_pkg::MIX_WIDTH'(int'($urandom_range(0, 511)) - 256);
			3: return ($urandom_range(0, 1) != 0) ? '1 : '0;
			default: return amos_pkg::MIX_WIDTH'($urandom());
		endcase
	endfunction

	// Lowpass, rounding, gain, saturation and ring placement for one pair.
	task automatic filter_and_scale_pair(input logic signed [amos_pkg::MIX_WIDTH-1:0] left,
			input logic signed [amos_pkg::MIX_WIDTH-1:0] right, input logic eob);
		longint      mix;
		longint      diff;
		longint      rounded;
		longint      scaled;
		longint      alpha;
		longint      gain;
		int          ring_log2;
		int          beats;
		logic [amos_pkg::SLOT_W-1:0]   ring_mask;
		logic [amos_pkg::SAMPLE_W-1:0] sample [2];
		ring_write_t                   beat;

		alpha = (shadow_alpha > amos_pkg::RST_FILTER_ALPHA)
			? longint'(amos_pkg::RST_FILTER_ALPHA) : longint'(shadow_alpha);
		gain = (shadow_volume > amos_pkg::VOL_UNITY) ? longint'(amos_pkg::VOL_UNITY)
			: longint'(shadow_volume);
		ring_log2 = int'(shadow_ring_log2);
		if (ring_log2 < int'(amos_pkg::RING_LOG2_MIN))
			ring_log2 = int'(amos_pkg::RING_LOG2_MIN);
		if (ring_log2 > int'(amos_pkg::RING_LOG2_MAX))
			ring_log2 = int'(amos_pkg::RING_LOG2_MAX);
		ring_mask = amos_pkg::SLOT_W'((32'd1 << ring_log2) - 1);

		// Both sides always advance, even when only left is emitted.
		for (int side = 0; side < 2; side++) begin
			mix = (side == 0) ? longint'(left) : longint'(right);
			diff = mix * 65536 - lowpass_acc[side];
			lowpass_acc[side] += (diff * alpha + amos_pkg::HALF_LSB) >>> amos_pkg::FRAC_W;
			rounded = (lowpass_acc[side] + amos_pkg::HALF_LSB) >>> amos_pkg::FRAC_W;
			scaled = (rounded * gain) >>> amos_pkg::VOL_SHIFT;
			if (scaled > 32767)
				scaled = 32767;
			else if (scaled < -32768)
				scaled = -32768;
			if (shadow_eight_bit)
				scaled = (scaled >>> amos_pkg::BYTE_W) + longint'(amos_pkg::BYTE_OFFSET);
			sample[side] = scaled[amos_pkg::SAMPLE_W-1:0];
		end

		beats = shadow_stereo ? 2 : 1;
		for (int k = 0; k < beats; k++) begin
			next_slot &= ring_mask;
			beat.slot_address = next_slot;
			beat.sample_value = sample[k];
			beat.is_last = (k == beats - 1);
			beat.block_done = (k == beats - 1) && eob;
			pending_writes.push_back(beat);
			next_slot = (next_slot + 1'b1) & ring_mask;
		end
	endtask

	// Offer one pair after an optional gap and wait for the beat to be taken.
	task automatic send_pair(input logic signed [amos_pkg::MIX_WIDTH-1:0] left,
			input logic signed [amos_pkg::MIX_WIDTH-1:0] right, input logic eob);
		int gap;
		gap = tx_gaps_on ? gap_length() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= amos_pkg::IN_TDATA_W'({right, left});
		s_axis_tlast <= eob;
		do @(posedge clk); while (!s_axis_tready);
		filter_and_scale_pair(left, right, eob);
	endtask

	task automatic send_random_pair();
		send_pair(random_mix(), random_mix(), $urandom_range(0, 7) == 0);
	endtask

	// Stop offering, let every result arrive, then let the back go quiet.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [amos_pkg::CFG_IDX_W-1:0] index,
			input logic [amos_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			amos_pkg::REG_MASTER_VOLUME:  shadow_volume = value[amos_pkg::VOL_W-1:0];
			amos_pkg::REG_FILTER_ALPHA:   shadow_alpha = value[amos_pkg::ALPHA_W-1:0];
			amos_pkg::REG_EIGHT_BIT_MODE: shadow_eight_bit = value[0];
			amos_pkg::REG_STEREO_MODE:    shadow_stereo = value[0];
			amos_pkg::REG_RING_SIZE_LOG2: shadow_ring_log2 = value[amos_pkg::LOG2_W-1:0];
			default: ;
		endcase
	endtask

	// Writes every register once the block is idle; a spare index is written too.
	task automatic apply_settings(input logic [amos_pkg::VOL_W-1:0] volume,
			input logic [amos_pkg::ALPHA_W-1:0] alpha, input logic eight_bit,
			input logic stereo, input logic [amos_pkg::LOG2_W-1:0] ring_log2);
		wait_drained();
		write_reg(amos_pkg::REG_MASTER_VOLUME, amos_pkg::CFG_DATA_W'(volume));
		write_reg(amos_pkg::REG_FILTER_ALPHA, amos_pkg::CFG_DATA_W'(alpha));
		write_reg(amos_pkg::REG_EIGHT_BIT_MODE, amos_pkg::CFG_DATA_W'(eight_bit));
		write_reg(amos_pkg::REG_STEREO_MODE, amos_pkg::CFG_DATA_W'(stereo));
		write_reg(amos_pkg::REG_RING_SIZE_LOG2, amos_pkg::CFG_DATA_W'(ring_log2));
		write_reg(amos_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
			amos_pkg::CFG_DATA_W'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	// Full-scale, zero and sign-boundary pairs under the reset settings.
	task automatic test_extremes();
		send_pair(24'sh7fffff, 24'sh800000, 1'b0);
		send_pair(24'sh800000, 24'sh7fffff, 1'b1);
		send_pair(24'sh000000, 24'sh000000, 1'b0);
		send_pair(-24'sd1, 24'sd1, 1'b1);
		send_pair(24'sd1, -24'sd1, 1'b0);
		send_pair(24'sh555555, 24'shaaaaaa, 1'b0);
		send_pair(24'shaaaaaa, 24'sh555555, 1'b1);
	endtask

	// Each register at its extremes, including values that must saturate.
	task automatic test_registers();
		// Gain and coefficient above unity.
		apply_settings(amos_pkg::VOL_W'(511), amos_pkg::ALPHA_W'(131071), 1'b0, 1'b1,
			amos_pkg::LOG2_W'(14));
		send_pair(24'sh7fffff, 24'sh800000, 1'b0);
		send_pair(24'sh012345, -24'sh012345, 1'b1);
		// Zero gain and a frozen filter.
		apply_settings(amos_pkg::VOL_W'(0), amos_pkg::ALPHA_W'(0), 1'b0, 1'b1,
			amos_pkg::LOG2_W'(31));
		send_pair(24'sh7fffff, 24'sh800000, 1'b0);
		// Half steps on small negative inputs round half up, not toward zero.
		apply_settings(amos_pkg::VOL_UNITY, amos_pkg::ALPHA_W'(32768), 1'b0, 1'b1,
			amos_pkg::LOG2_W'(0));
		send_pair(-24'sd1, 24'sd1, 1'b0);
		send_pair(-24'sd1, -24'sd3, 1'b1);
		send_pair(24'sd0, -24'sd1, 1'b0);
		// Slowest filter, 8-bit output, mono, smallest ring.
		apply_settings(amos_pkg::VOL_UNITY, amos_pkg::ALPHA_W'(1), 1'b1, 1'b0,
			amos_pkg::RING_LOG2_MIN);
		send_pair(24'sh7fffff, 24'sh800000, 1'b0);
		send_pair(24'sh800000, 24'sh7fffff, 1'b1);
		// Pass-through, 8-bit extremes, largest ring.
		apply_settings(amos_pkg::VOL_UNITY, amos_pkg::RST_FILTER_ALPHA, 1'b1, 1'b1,
			amos_pkg::RING_LOG2_MAX);
		send_pair(24'sh7fffff, 24'sh800000, 1'b1);
		send_pair(-24'sd1, 24'sd0, 1'b0);
		// Mono with 16-bit output mid-stream.
		apply_settings(amos_pkg::VOL_W'(128), amos_pkg::ALPHA_W'(65535), 1'b0, 1'b0,
			amos_pkg::LOG2_W'(9));
		send_pair(24'sh400000, 24'sh800000, 1'b1);
		send_pair(24'shc00000, 24'sh7fffff, 1'b0);
	endtask

	task automatic randomize_settings();
		logic [amos_pkg::VOL_W-1:0]   volume;
		logic [amos_pkg::ALPHA_W-1:0] alpha;
		logic [amos_pkg::LOG2_W-1:0]  ring_log2;
		case ($urandom_range(0, 3))
			0: volume = amos_pkg::VOL_UNITY;
			1: volume = amos_pkg::VOL_W'($urandom_range(257, 511));
			default: volume = amos_pkg::VOL_W'($urandom_range(0, 256));
		endcase
		case ($urandom_range(0, 4))
			0: alpha = amos_pkg::RST_FILTER_ALPHA;
			1: alpha = amos_pkg::ALPHA_W'($urandom_range(65537, 131071));
			2: alpha = amos_pkg::ALPHA_W'($urandom_range(0, 255));
			default: alpha = amos_pkg::ALPHA_W'($urandom_range(0, 65536));
		endcase
		if ($urandom_range(0, 1) != 0)
			ring_log2 = amos_pkg::LOG2_W'($urandom_range(0, 31));
		else
			ring_log2 = amos_pkg::LOG2_W'($urandom_range(8, 10));
		apply_settings(volume, alpha, $urandom_range(0, 1) != 0, $urandom_range(0, 3) != 0,
			ring_log2);
	endtask

	// Random pairs in phases, each under fresh settings and its own idling mix.
	task automatic test_random_stream();
		for (int phase = 0; phase < PHASES; phase++) begin
			randomize_settings();
			tx_gaps_on = (phase != 3) && (phase != 6);
			rx_gaps_on <= (phase != 4) && (phase != 6);
			repeat (PHASE_PAIRS) send_random_pair();
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on <= 1'b1;
	endtask

	// The receiver holds off while pairs keep coming until the input stalls.
	task automatic test_backpressure();
		apply_settings(amos_pkg::VOL_W'(200), amos_pkg::ALPHA_W'(40000), 1'b0, 1'b1,
			amos_pkg::LOG2_W'(8));
		tx_gaps_on = 1'b0;
		hold_req <= hold_req + 1;
		repeat (BURST_PAIRS) send_random_pair();
		tx_gaps_on = 1'b1;
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_registers();
		test_backpressure();
		test_random_stream();
		wait_drained();
		if (bad_beats == 0 && pending_writes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Output side: random stalls, and one long hold when asked for.
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			rx_stall <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (rx_stall != 0) begin
			rx_stall <= rx_stall - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
			rx_stall <= gap_length();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic report_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		$display("%0t ns: %s mismatch, expected 0x%04h, got 0x%04h", $time, field, want, got);
		bad_beats++;
	endtask

	// Each output beat against the oldest predicted ring write.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_writes.size() == 0) begin
				$display("%0t ns: unexpected output beat, expected none, got 0x%08h",
					$time, m_axis_tdata);
				bad_beats++;
			end else begin
				oldest_write = pending_writes.pop_front();
				if (m_axis_tdata[amos_pkg::SLOT_W-1:0] !== oldest_write.slot_address)
					report_field("slot_address", oldest_write.slot_address,
						m_axis_tdata[amos_pkg::SLOT_W-1:0]);
				if (m_axis_tdata[amos_pkg::SLOT_W+amos_pkg::SAMPLE_W-1:amos_pkg::SLOT_W]
						!== oldest_write.sample_value)
					report_field("sample_value", oldest_write.sample_value,
						m_axis_tdata[amos_pkg::SLOT_W+amos_pkg::SAMPLE_W-1:amos_pkg::SLOT_W]);
				if (m_axis_tuser !== oldest_write.is_last)
					report_field("is_last", 16'(oldest_write.is_last), 16'(m_axis_tuser));
				if (m_axis_tlast !== oldest_write.block_done)
					report_field("block_done", 16'(oldest_write.block_done), 16'(m_axis_tlast));
			end
		end
	end

	// Ends the run when no channel has moved a beat for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
